// ===== rtl/core/psc_pkg.sv =====
// Shared types and constants for the pair sum complement finder.
package psc_pkg;

    localparam int DATA_W = 32;
    localparam int IDX_W  = 6;

    localparam logic REG_TARGET_SUM = 1'b0;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_UPD  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    typedef struct packed {
        logic val_we;
        logic pos_we;
    } t_wr_ctl;

endpackage

// ===== rtl/core/psc_store.sv =====
// Entry store: value and position memories with one write port and a registered read port.
module psc_store import psc_pkg::*; #(
    parameter int MAX_ITEMS = 64,
    parameter int AW        = 6
) (
    input  logic              i_clk,
    input  t_wr_ctl           i_wr_ctl,
    input  logic [AW-1:0]     i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_value,
    input  logic [AW-1:0]     i_wr_pos,
    input  logic [AW-1:0]     i_rd_addr,
    output logic [DATA_W-1:0] o_rd_value,
    output logic [AW-1:0]     o_rd_pos
);

    logic [DATA_W-1:0] r_mem_value [MAX_ITEMS];
    logic [AW-1:0]     r_mem_pos   [MAX_ITEMS];
    logic [DATA_W-1:0] r_rd_value;
    logic [AW-1:0]     r_rd_pos;

    always_ff @(posedge i_clk) begin
        if (i_wr_ctl.val_we) begin
            r_mem_value[i_wr_addr] <= i_wr_value;
        end
        if (i_wr_ctl.pos_we) begin
            r_mem_pos[i_wr_addr] <= i_wr_pos;
        end
        r_rd_value <= r_mem_value[i_rd_addr];
        r_rd_pos   <= r_mem_pos[i_rd_addr];
    end

    assign o_rd_value = r_rd_value;
    assign o_rd_pos   = r_rd_pos;

endmodule

// ===== rtl/core/psc_seq.sv =====
// Sequencer and shared comparator that walk the store for each item within capacity.
module psc_seq import psc_pkg::*; #(
    parameter int MAX_ITEMS = 64,
    parameter int AW        = 6,
    parameter int CW        = 7
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [DATA_W-1:0] i_value,
    input  logic              i_first,
    input  logic [DATA_W-1:0] i_target,
    input  logic              i_out_free,
    output logic              o_res_valid,
    output logic [AW-1:0]     o_res_earlier,
    output logic [AW-1:0]     o_res_later,
    output logic              o_res_overflow,
    output t_wr_ctl           o_wr_ctl,
    output logic [AW-1:0]     o_wr_addr,
    output logic [DATA_W-1:0] o_wr_value,
    output logic [AW-1:0]     o_wr_pos,
    output logic [AW-1:0]     o_rd_addr,
    input  logic [DATA_W-1:0] i_rd_value,
    input  logic [AW-1:0]     i_rd_pos
);

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_pos, n_pos;
    logic              r_ovf, n_ovf;
    logic [DATA_W-1:0] r_value, n_value;
    logic [DATA_W-1:0] r_comp, n_comp;
    logic              r_comp_ok, n_comp_ok;
    logic [AW-1:0]     r_cur_pos, n_cur_pos;
    logic [CW-1:0]     r_scan, n_scan;
    logic              r_pend, n_pend;
    logic [AW-1:0]     r_pend_idx, n_pend_idx;
    logic              r_dup, n_dup;
    logic [AW-1:0]     r_dup_idx, n_dup_idx;
    logic [AW-1:0]     r_res_earlier, n_res_earlier;
    logic [AW-1:0]     r_res_later, n_res_later;
    logic              r_res_ovf, n_res_ovf;

    logic              w_accept;
    logic [CW-1:0]     w_eff_pos;
    logic [CW-1:0]     w_eff_count;
    logic              w_eff_ovf;
    logic [DATA_W:0]   w_comp;
    logic              w_issue;
    logic              w_hit;
    logic              w_dup;

    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign w_eff_pos   = i_first ? '0 : r_pos;
    assign w_eff_count = i_first ? '0 : r_count;
    assign w_eff_ovf   = i_first ? 1'b0 : r_ovf;
    assign w_comp      = {i_target[DATA_W-1], i_target} - {i_value[DATA_W-1], i_value};
    assign w_issue     = (r_state == S_SCAN) && (r_scan < r_count);
    assign w_hit       = r_pend && r_comp_ok && (i_rd_value == r_comp);
    assign w_dup       = r_pend && (i_rd_value == r_value);

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_pos         = r_pos;
        n_ovf         = r_ovf;
        n_value       = r_value;
        n_comp        = r_comp;
        n_comp_ok     = r_comp_ok;
        n_cur_pos     = r_cur_pos;
        n_scan        = r_scan;
        n_pend        = r_pend;
        n_pend_idx    = r_pend_idx;
        n_dup         = r_dup;
        n_dup_idx     = r_dup_idx;
        n_res_earlier = r_res_earlier;
        n_res_later   = r_res_later;
        n_res_ovf     = r_res_ovf;
        o_res_valid   = 1'b0;
        o_wr_ctl      = '0;
        o_wr_addr     = r_dup_idx;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_count = w_eff_count;
                    n_ovf   = w_eff_ovf;
                    if (w_eff_pos >= CW'(MAX_ITEMS)) begin
                        n_pos = w_eff_pos;
                        n_ovf = 1'b1;
                        if (!w_eff_ovf) begin
                            n_res_earlier = '0;
                            n_res_later   = '0;
                            n_res_ovf     = 1'b1;
                            n_state       = S_OUT;
                        end
                    end else begin
                        n_pos     = CW'(w_eff_pos + 1'b1);
                        n_cur_pos = w_eff_pos[AW-1:0];
                        n_value   = i_value;
                        n_comp    = w_comp[DATA_W-1:0];
                        n_comp_ok = (w_comp[DATA_W] == w_comp[DATA_W-1]);
                        n_scan    = '0;
                        n_pend    = 1'b0;
                        n_dup     = 1'b0;
                        n_state   = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                n_pend     = w_issue;
                n_pend_idx = r_scan[AW-1:0];
                if (w_issue) begin
                    n_scan = CW'(r_scan + 1'b1);
                end
                if (w_hit) begin
                    n_res_earlier = i_rd_pos;
                    n_res_later   = r_cur_pos;
                    n_res_ovf     = 1'b0;
                    n_state       = S_OUT;
                end else begin
                    if (w_dup) begin
                        n_dup     = 1'b1;
                        n_dup_idx = r_pend_idx;
                    end
                    if (!w_issue) begin
                        n_state = S_UPD;
                    end
                end
            end
            S_UPD: begin
                if (r_dup) begin
                    o_wr_ctl.pos_we = 1'b1;
                    o_wr_addr       = r_dup_idx;
                end else if (r_count < CW'(MAX_ITEMS)) begin
                    o_wr_ctl.val_we = 1'b1;
                    o_wr_ctl.pos_we = 1'b1;
                    o_wr_addr       = r_count[AW-1:0];
                    n_count         = CW'(r_count + 1'b1);
                end
                n_state = S_IDLE;
            end
            S_OUT: begin
                if (i_out_free) begin
                    o_res_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pos   <= '0;
            r_ovf   <= 1'b0;
            r_pend  <= 1'b0;
            r_dup   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pos   <= n_pos;
            r_ovf   <= n_ovf;
            r_pend  <= n_pend;
            r_dup   <= n_dup;
        end
        r_value       <= n_value;
        r_comp        <= n_comp;
        r_comp_ok     <= n_comp_ok;
        r_cur_pos     <= n_cur_pos;
        r_scan        <= n_scan;
        r_pend_idx    <= n_pend_idx;
        r_dup_idx     <= n_dup_idx;
        r_res_earlier <= n_res_earlier;
        r_res_later   <= n_res_later;
        r_res_ovf     <= n_res_ovf;
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_res_earlier  = r_res_earlier;
    assign o_res_later    = r_res_later;
    assign o_res_overflow = r_res_ovf;
    assign o_wr_value     = r_value;
    assign o_wr_pos       = r_cur_pos;
    assign o_rd_addr      = r_scan[AW-1:0];

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ITEMS))
        else $error("entry count exceeds capacity");

    a_count_le_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_pos)
        else $error("more entries stored than positions handed out");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_scan <= r_count))
        else $error("scan pointer ran past the stored entries");

    a_write_in_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_wr_ctl.val_we || o_wr_ctl.pos_we) |-> (r_state == S_UPD))
        else $error("store written outside the update step");

    a_res_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> (r_state == S_IDLE))
        else $error("sequencer did not return to idle after a result");
`endif

endmodule

// ===== rtl/core/pair_sum_complement_finder_unit.sv =====
// Top level of the pair sum complement finder: register port, output register and core.
// Each item is checked against the stored values of the current array for its complement,
// target_sum minus value, by a single comparator that walks the stored entries one per cycle
// out of a memory with a registered read port. The walk stops at the first matching entry;
// with no pair it covers every stored entry. An item beyond capacity is not searched, and
// only the first such item reports the overflow. The input stalls while an item is at work.
// A result moves into an output register, and the next item is taken while it waits there.
// The exception is when that register still holds an earlier result that is stalled.
// target_sum sits at byte address 0; the user must see that it is written only while the
// block is idle, which the block itself does not enforce.
module pair_sum_complement_finder_unit import psc_pkg::*; #(
    parameter int MAX_ITEMS = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic                     i_first,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic        [IDX_W-1:0]  o_earlier_index,
    output logic        [IDX_W-1:0]  o_later_index,
    output logic                     o_overflow,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic        [2:0]        paddr,
    input  logic        [31:0]       pwdata,
    output logic        [31:0]       prdata,
    output logic                     pready
);

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int PW = (AW > IDX_W) ? AW : IDX_W;

    logic [DATA_W-1:0] r_target;
    logic              r_out_valid;
    logic [IDX_W-1:0]  r_out_earlier;
    logic [IDX_W-1:0]  r_out_later;
    logic              r_out_ovf;

    logic              w_out_free;
    logic              w_res_valid;
    logic [AW-1:0]     w_res_earlier;
    logic [AW-1:0]     w_res_later;
    logic              w_res_ovf;
    logic [PW-1:0]     w_earlier_wide;
    logic [PW-1:0]     w_later_wide;
    t_wr_ctl           w_wr_ctl;
    logic [AW-1:0]     w_wr_addr;
    logic [DATA_W-1:0] w_wr_value;
    logic [AW-1:0]     w_wr_pos;
    logic [AW-1:0]     w_rd_addr;
    logic [DATA_W-1:0] w_rd_value;
    logic [AW-1:0]     w_rd_pos;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TARGET_SUM) ? r_target : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
        end else if (psel && penable && pwrite && (paddr[2] == REG_TARGET_SUM)) begin
            r_target <= pwdata;
        end
    end

    assign w_out_free     = !r_out_valid || !i_out_stall;
    assign w_earlier_wide = PW'(w_res_earlier);
    assign w_later_wide   = PW'(w_res_later);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (w_res_valid) begin
            r_out_earlier <= w_earlier_wide[IDX_W-1:0];
            r_out_later   <= w_later_wide[IDX_W-1:0];
            r_out_ovf     <= w_res_ovf;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_earlier_index = r_out_earlier;
    assign o_later_index   = r_out_later;
    assign o_overflow      = r_out_ovf;

    psc_seq #(
        .MAX_ITEMS (MAX_ITEMS),
        .AW        (AW),
        .CW        (CW)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_value        (i_value),
        .i_first        (i_first),
        .i_target       (r_target),
        .i_out_free     (w_out_free),
        .o_res_valid    (w_res_valid),
        .o_res_earlier  (w_res_earlier),
        .o_res_later    (w_res_later),
        .o_res_overflow (w_res_ovf),
        .o_wr_ctl       (w_wr_ctl),
        .o_wr_addr      (w_wr_addr),
        .o_wr_value     (w_wr_value),
        .o_wr_pos       (w_wr_pos),
        .o_rd_addr      (w_rd_addr),
        .i_rd_value     (w_rd_value),
        .i_rd_pos       (w_rd_pos)
    );

    psc_store #(
        .MAX_ITEMS (MAX_ITEMS),
        .AW        (AW)
    ) u_store (
        .i_clk      (i_clk),
        .i_wr_ctl   (w_wr_ctl),
        .i_wr_addr  (w_wr_addr),
        .i_wr_value (w_wr_value),
        .i_wr_pos   (w_wr_pos),
        .i_rd_addr  (w_rd_addr),
        .o_rd_value (w_rd_value),
        .o_rd_pos   (w_rd_pos)
    );

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the pair sum complement finder, with a built-in scoreboard.
module testbench;
    import psc_pkg::*;

    localparam int CAPACITY     = 64;
    localparam int SETTLE       = CAPACITY + 8;
    localparam int LIMIT        = 2_000_000;
    localparam int RANDOM_ITEMS = 2000;
    localparam int PHASE_ITEMS  = 250;

    localparam logic [2:0] TARGET_SUM_ADDR = {REG_TARGET_SUM, 2'b00};
    localparam logic signed [DATA_W-1:0] INT32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] INT32_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [IDX_W-1:0] earlier;
        logic [IDX_W-1:0] later;
        logic             overflow;
    } t_pair_result;

    typedef enum int {
        STALL_NONE,
        STALL_SOME,
        STALL_HEAVY
    } t_stall_mode;

    class pair_sum_scoreboard #(int DEPTH = 64);
        logic signed [DATA_W-1:0] target;
        logic signed [DATA_W-1:0] stored_val [DEPTH];
        int                       stored_pos [DEPTH];
        int                       entries;
        int                       position;
        bit                       overflowed;
        t_pair_result             expected [$];
        int                       errors;

        function new();
            target     = '0;
            entries    = 0;
            position   = 0;
            overflowed = 1'b0;
            errors     = 0;
        endfunction

        function void note_item(logic signed [DATA_W-1:0] v, logic first);
            longint       comp;
            int           pos;
            t_pair_result res;
            if (first) begin
                entries    = 0;
                position   = 0;
                overflowed = 1'b0;
            end
            if (position >= DEPTH) begin
                if (!overflowed) begin
                    overflowed   = 1'b1;
                    res.earlier  = '0;
                    res.later    = '0;
                    res.overflow = 1'b1;
                    expected.insert(expected.size(), res);
                end
                return;
            end
            pos = position;
            position++;
            comp = longint'(target) - longint'(v);
            if (comp >= longint'(INT32_MIN) && comp <= longint'(INT32_MAX)) begin
                for (int k = 0; k < entries; k++) begin
                    if (longint'(stored_val[k]) == comp) begin
                        res.earlier  = IDX_W'(stored_pos[k]);
                        res.later    = IDX_W'(pos);
                        res.overflow = overflowed;
                        expected.insert(expected.size(), res);
                        return;
                    end
                end
            end
            for (int k = 0; k < entries; k++) begin
                if (stored_val[k] == v) begin
                    stored_pos[k] = pos;
                    return;
                end
            end
            if (entries < DEPTH) begin
                stored_val[entries] = v;
                stored_pos[entries] = pos;
                entries++;
            end
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_result(logic [IDX_W-1:0] earlier, logic [IDX_W-1:0] later, logic ovf);
            t_pair_result want;
            if (expected.size() == 0) begin
                report($sformatf("result with none expected: earlier %0d later %0d overflow %0b",
                                 earlier, later, ovf));
                return;
            end
            want = expected.pop_front();
            if (earlier !== want.earlier)
                report($sformatf("earlier_index %0d, expected %0d", earlier, want.earlier));
            if (later !== want.later)
                report($sformatf("later_index %0d, expected %0d", later, want.later));
            if (ovf !== want.overflow)
                report($sformatf("overflow %0b, expected %0b", ovf, want.overflow));
        endtask
    endclass

    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     i_in_valid  = 1'b0;
    logic                     o_in_stall;
    logic signed [DATA_W-1:0] i_value     = '0;
    logic                     i_first     = 1'b0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic        [IDX_W-1:0]  o_earlier_index;
    logic        [IDX_W-1:0]  o_later_index;
    logic                     o_overflow;
    logic                     psel        = 1'b0;
    logic                     penable     = 1'b0;
    logic                     pwrite      = 1'b0;
    logic        [2:0]        paddr       = '0;
    logic        [31:0]       pwdata      = '0;
    logic        [31:0]       prdata;
    logic                     pready;

    pair_sum_scoreboard #(CAPACITY) sb;

    int          burst_left = 0;
    int          cycles     = 0;
    t_stall_mode stall_mode = STALL_NONE;
    int          stall_run  = 0;

    pair_sum_complement_finder_unit #(
        .MAX_ITEMS(CAPACITY)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_value        (i_value),
        .i_first        (i_first),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_earlier_index(o_earlier_index),
        .o_later_index  (o_later_index),
        .o_overflow     (o_overflow),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_earlier_index, o_later_index, o_overflow);
    end

    always @(negedge i_clk) begin
        if (stall_run == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 2));
            stall_run  = $urandom_range(20, 200);
        end else begin
            stall_run--;
        end
        case (stall_mode)
            STALL_NONE: i_out_stall <= 1'b0;
            STALL_SOME: i_out_stall <= $urandom_range(0, 1);
            default: i_out_stall <= ($urandom_range(0, 9) != 0);
        endcase
    end

    // Entered and left at a falling edge; the valid stays high between items of a burst.
    task automatic send_item(input logic signed [DATA_W-1:0] v, input logic first);
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_value    <= v;
        i_first    <= first;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_item(v, first);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (sb.expected.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_target_sum(input logic signed [DATA_W-1:0] t);
        logic [31:0] rd;
        drain_results();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= TARGET_SUM_ADDR;
        pwdata  <= t;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.target = t;
        @(negedge i_clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd !== t)
            sb.report($sformatf("target_sum reads back %h, written %h", rd, t));
    endtask

    // Most values are complements or repeats of earlier ones so that pairs turn up often.
    task automatic send_random_array(input int len);
        logic signed [DATA_W-1:0] seen [$];
        logic signed [DATA_W-1:0] v;
        int                       pick;
        int                       n;
        for (n = 0; n < len; n++) begin
            pick = $urandom_range(0, 9);
            if (seen.size() != 0 && pick < 4)
                v = sb.target - seen[$urandom_range(0, seen.size() - 1)];
            else if (seen.size() != 0 && pick < 6)
                v = seen[$urandom_range(0, seen.size() - 1)];
            else if (pick < 8)
                v = $signed($urandom_range(0, 16)) - 8;
            else
                v = $urandom;
            seen.insert(seen.size(), v);
            send_item(v, n == 0);
        end
    endtask

    initial begin
        int                       total;
        int                       len;
        int                       phase;
        logic signed [DATA_W-1:0] t;
        sb = new();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Items before any first flag form one array, under the target left by reset.
        send_item(5, 1'b0);
        send_item(5, 1'b0);
        send_item(-5, 1'b0);
        send_item(INT32_MIN, 1'b1);
        send_item(INT32_MAX, 1'b0);
        send_item(-INT32_MAX, 1'b0);
        send_item(0, 1'b0);
        send_item(0, 1'b0);
        write_target_sum(INT32_MAX);
        send_item(-1, 1'b1);
        send_item(0, 1'b0);
        send_item(INT32_MAX, 1'b0);
        write_target_sum(INT32_MIN);
        send_item(1, 1'b1);
        send_item(0, 1'b0);
        send_item(INT32_MIN, 1'b0);
        send_item(-1, 1'b0);

        total = 0;
        for (phase = 0; total < RANDOM_ITEMS; phase++) begin
            case (phase)
                0: t = INT32_MAX;
                1: t = INT32_MIN;
                2: t = -1;
                3: t = 0;
                default: t = $urandom;
            endcase
            write_target_sum(t);
            while (total < (phase + 1) * PHASE_ITEMS && total < RANDOM_ITEMS) begin
                if ($urandom_range(0, 24) == 0)
                    len = $urandom_range(CAPACITY + 1, CAPACITY + 16);
                else
                    len = $urandom_range(1, 20);
                send_random_array(len);
                total += len;
            end
        end

        drain_results();
        if (sb.errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end
endmodule
